[hw/rtl/bisc_pkg.sv]
`default_nettype none

package bisc_pkg;

    // Default sizing of the scanner.
    localparam int MAX_DEPTH_DEF   = 32;
    localparam int OFFSET_BITS_DEF = 32;

    // Width of the offsets carried in a result transaction.
    localparam int RESULT_BITS = 32;

    // Bencode characters that steer the scan.
    localparam logic [7:0] CH_DICT  = 8'h64;  // 'd'
    localparam logic [7:0] CH_INT   = 8'h69;  // 'i'
    localparam logic [7:0] CH_LIST  = 8'h6C;  // 'l'
    localparam logic [7:0] CH_END   = 8'h65;  // 'e'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // Container kinds held on the nesting stack.
    localparam logic KIND_LIST = 1'b0;
    localparam logic KIND_DICT = 1'b1;

    // Key match progress: four matched characters, or no match possible.
    localparam logic [3:0] KEY_LEN_INFO = 4'd4;
    localparam logic [3:0] NO_MATCH     = 4'd15;

    // One result transaction.
    typedef struct packed {
        logic                   found;
        logic [RESULT_BITS-1:0] span_start;
        logic [RESULT_BITS-1:0] span_end;
    } t_result;

    // Commands to the nesting stack.
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic kind;
    } t_stack_cmd;

    // Status of the nesting stack.
    typedef struct packed {
        logic empty;
        logic single;
        logic full;
        logic top_kind;
        logic below_kind;
    } t_stack_stat;

    // Character of the key "info" at a given position.
    function automatic logic [7:0] info_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h69;  // 'i'
            2'd1: c = 8'h6E;  // 'n'
            2'd2: c = 8'h66;  // 'f'
            2'd3: c = 8'h6F;  // 'o'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // True for an ASCII decimal digit.
    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bisc_if.sv]
`default_nettype none

// Byte stream into the scanner.
interface bisc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result stream out of the scanner.
interface bisc_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] span_start;
    logic [31:0] span_end;

    modport source (output valid, output found, output span_start, output span_end,
                    input ready);
    modport sink   (input valid, input found, input span_start, input span_end,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/bisc_stack.sv]
`default_nettype none

// Nesting stack of container kinds. The kinds live in a synchronous memory;
// the two topmost kinds are mirrored in registers, and the entry below those
// is prefetched into a register so that back-to-back pops see it in time.
module bisc_stack #(
    parameter int MAX_DEPTH = bisc_pkg::MAX_DEPTH_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire bisc_pkg::t_stack_cmd i_cmd,
    output bisc_pkg::t_stack_stat     o_stat
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = $clog2(MAX_DEPTH);

    logic          r_mem [MAX_DEPTH];
    logic [DW-1:0] r_depth;
    logic [DW-1:0] n_depth;
    logic [DW-1:0] w_rd_ptr;
    logic          r_rd_kind;
    logic          r_top_kind;
    logic          r_below_kind;

    // Depth counter.
    always_comb begin
        n_depth = r_depth;
        if (i_cmd.clear) begin
            n_depth = '0;
        end else if (i_cmd.push) begin
            n_depth = r_depth + DW'(1);
        end else if (i_cmd.pop) begin
            n_depth = r_depth - DW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    // Prefetch the entry third from the top of the next depth.
    assign w_rd_ptr = n_depth - DW'(3);

    // Memory: one write on a push, one registered read every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.clear) begin
            r_mem[r_depth[AW-1:0]] <= i_cmd.kind;
        end
        r_rd_kind <= r_mem[w_rd_ptr[AW-1:0]];
    end

    // Registered copies of the two topmost kinds.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.clear) begin
            r_top_kind   <= i_cmd.kind;
            r_below_kind <= r_top_kind;
        end else if (i_cmd.pop && !i_cmd.clear) begin
            r_top_kind   <= r_below_kind;
            r_below_kind <= r_rd_kind;
        end
    end

    assign o_stat.empty      = (r_depth == '0);
    assign o_stat.single     = (r_depth == DW'(1));
    assign o_stat.full       = (r_depth == DW'(MAX_DEPTH));
    assign o_stat.top_kind   = r_top_kind;
    assign o_stat.below_kind = r_below_kind;

endmodule

`default_nettype wire

[hw/rtl/bisc_out_buf.sv]
`default_nettype none

// Two-entry result queue between the scanner and the output channel.
module bisc_out_buf (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire bisc_pkg::t_result i_data,
    output logic                   o_full,
    bisc_out_if.source             o_out
);

    bisc_pkg::t_result r_q0;
    bisc_pkg::t_result r_q1;
    logic [1:0]        r_count;
    logic [1:0]        n_count;
    logic              w_pop;
    logic              w_to_head;

    assign w_pop = o_out.valid && o_out.ready;

    // A new result lands in the head when the queue is empty or is being
    // emptied in the same cycle.
    assign w_to_head = (r_count == 2'd0) || (r_count == 2'd1 && w_pop);

    // Occupancy.
    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Entry shifting: the head is always in r_q0.
    always_ff @(posedge i_clk) begin
        if (i_push && w_to_head) begin
            r_q0 <= i_data;
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end
        if (i_push && !w_to_head) begin
            r_q1 <= i_data;
        end
    end

    assign o_full           = (r_count == 2'd2);
    assign o_out.valid      = (r_count != 2'd0);
    assign o_out.found      = r_q0.found;
    assign o_out.span_start = r_q0.span_start;
    assign o_out.span_end   = r_q0.span_end;

endmodule

`default_nettype wire

[hw/rtl/bencode_info_range_scanner.sv]
// Channel   Dir  Signals                                 Transaction
// i_in      in   valid, ready, data_byte, last_byte      one file byte
// o_out     out  valid, ready, found, span_start,        one result per file
//                span_end
//
// One byte is taken every cycle while the two-entry result queue has room.
// Each byte costs a single pass through the scan logic and at most one push
// or pop of the nesting stack memory; a prefetched read keeps pops at full rate.
// A result is queued at the edge that accepts its byte and shown from the next cycle.
// Reset is synchronous and active low; it clears the scan state and the queue.
// The output side stalls the input only when two results are waiting.
`default_nettype none

module bencode_info_range_scanner #(
    parameter int MAX_DEPTH   = bisc_pkg::MAX_DEPTH_DEF,
    parameter int OFFSET_BITS = bisc_pkg::OFFSET_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bisc_in_if.sink    i_in,
    bisc_out_if.source o_out
);

    localparam int OB = OFFSET_BITS;
    localparam int OW = (OFFSET_BITS > bisc_pkg::RESULT_BITS) ? OFFSET_BITS
                                                              : bisc_pkg::RESULT_BITS;

    // Scan modes.
    localparam logic [3:0] MODE_ROOT_OPEN  = 4'd0;
    localparam logic [3:0] MODE_KEY_START  = 4'd1;
    localparam logic [3:0] MODE_KEY_LEN    = 4'd2;
    localparam logic [3:0] MODE_KEY_BODY   = 4'd3;
    localparam logic [3:0] MODE_VALUE      = 4'd4;
    localparam logic [3:0] MODE_LIST_ITEM  = 4'd5;
    localparam logic [3:0] MODE_STR_LEN    = 4'd6;
    localparam logic [3:0] MODE_STR_BODY   = 4'd7;
    localparam logic [3:0] MODE_INT_BODY   = 4'd8;

    logic [3:0]    r_mode;
    logic [3:0]    n_mode;
    logic [OB-1:0] r_off;
    logic [OB-1:0] n_off;
    logic [OB-1:0] r_rem;
    logic [OB-1:0] n_rem;
    logic [3:0]    r_kmp;
    logic [3:0]    n_kmp;
    logic          r_cur_info;
    logic          n_cur_info;
    logic [OB-1:0] r_info_begin;
    logic [OB-1:0] n_info_begin;
    logic          r_decided;
    logic          n_decided;

    logic                  w_accept;
    logic                  w_full;
    logic [7:0]            w_byte;
    logic                  w_last;
    logic                  w_digit;
    logic [3:0]            w_dval;
    logic [OB+3:0]         w_rem_x10;
    logic                  w_sat;
    logic                  w_match;
    bisc_pkg::t_stack_cmd  w_stk_cmd;
    bisc_pkg::t_stack_stat w_stk;

    logic          w_dec;
    logic          w_dec_found;
    logic [OB-1:0] w_dec_start;
    logic [OB-1:0] w_dec_end;
    logic          w_bv;
    logic          w_bv_dict;
    logic          w_kd;
    logic          w_vd;
    logic          w_vd_pop;
    logic          w_vd_root;
    logic          w_vd_kind;
    logic [OW-1:0] w_start_wide;
    logic [OW-1:0] w_end_wide;
    bisc_pkg::t_result w_res;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = !w_full;
    assign w_byte = i_in.data_byte;
    assign w_last = i_in.last_byte;

    // Length digit accumulation with saturation check: ten times the length
    // plus the digit must still fit in the offset width.
    assign w_digit   = bisc_pkg::is_digit(w_byte);
    assign w_dval    = 4'(w_byte - bisc_pkg::CH_ZERO);
    assign w_rem_x10 = ({4'b0, r_rem} << 3) + ({4'b0, r_rem} << 1) + (OB + 4)'(w_dval);
    assign w_sat     = |w_rem_x10[OB+3:OB];

    // Key comparison against "info".
    assign w_match = (r_kmp < bisc_pkg::KEY_LEN_INFO) &&
                     (w_byte == bisc_pkg::info_char(r_kmp[1:0]));

    // Next-state logic of the scanner.
    always_comb begin
        n_mode       = r_mode;
        n_off        = r_off;
        n_rem        = r_rem;
        n_kmp        = r_kmp;
        n_cur_info   = r_cur_info;
        n_info_begin = r_info_begin;
        n_decided    = r_decided;
        w_stk_cmd    = '0;
        w_dec        = 1'b0;
        w_dec_found  = 1'b0;
        w_dec_start  = '0;
        w_dec_end    = '0;
        w_bv         = 1'b0;
        w_bv_dict    = 1'b0;
        w_kd         = 1'b0;
        w_vd         = 1'b0;
        w_vd_pop     = 1'b0;
        w_vd_root    = 1'b0;
        w_vd_kind    = 1'b0;

        if (w_accept) begin
            if (!r_decided) begin
                // Per-mode byte handling.
                unique case (r_mode)
                    MODE_ROOT_OPEN: begin
                        if (w_byte == bisc_pkg::CH_DICT) begin
                            n_mode = MODE_KEY_START;
                        end else begin
                            w_dec = 1'b1;
                        end
                    end
                    MODE_KEY_START: begin
                        if (w_byte == bisc_pkg::CH_END) begin
                            if (w_stk.empty) begin
                                w_dec = 1'b1;
                            end else begin
                                w_stk_cmd.pop = 1'b1;
                                w_vd          = 1'b1;
                                w_vd_pop      = 1'b1;
                            end
                        end else if (w_digit) begin
                            n_rem  = OB'(w_dval);
                            n_mode = MODE_KEY_LEN;
                        end else begin
                            w_dec = 1'b1;
                        end
                    end
                    MODE_KEY_LEN: begin
                        if (w_digit) begin
                            if (w_sat) begin
                                w_dec = 1'b1;
                            end else begin
                                n_rem = w_rem_x10[OB-1:0];
                            end
                        end else if (w_byte == bisc_pkg::CH_COLON) begin
                            n_kmp = (r_rem == OB'(4)) ? 4'd0 : bisc_pkg::NO_MATCH;
                            if (r_rem == '0) begin
                                w_kd = 1'b1;
                            end else begin
                                n_mode = MODE_KEY_BODY;
                            end
                        end else begin
                            w_dec = 1'b1;
                        end
                    end
                    MODE_KEY_BODY: begin
                        n_kmp = w_match ? (r_kmp + 4'd1) : bisc_pkg::NO_MATCH;
                        n_rem = r_rem - OB'(1);
                        if (r_rem == OB'(1)) begin
                            w_kd = 1'b1;
                        end
                    end
                    MODE_VALUE: begin
                        w_bv      = 1'b1;
                        w_bv_dict = 1'b1;
                    end
                    MODE_LIST_ITEM: begin
                        if (w_byte == bisc_pkg::CH_END) begin
                            w_stk_cmd.pop = 1'b1;
                            w_vd          = 1'b1;
                            w_vd_pop      = 1'b1;
                        end else begin
                            w_bv = 1'b1;
                        end
                    end
                    MODE_STR_LEN: begin
                        if (w_digit) begin
                            if (w_sat) begin
                                w_dec = 1'b1;
                            end else begin
                                n_rem = w_rem_x10[OB-1:0];
                            end
                        end else if (w_byte == bisc_pkg::CH_COLON) begin
                            if (r_rem == '0) begin
                                w_vd = 1'b1;
                            end else begin
                                n_mode = MODE_STR_BODY;
                            end
                        end else begin
                            w_dec = 1'b1;
                        end
                    end
                    MODE_STR_BODY: begin
                        n_rem = r_rem - OB'(1);
                        if (r_rem == OB'(1)) begin
                            w_vd = 1'b1;
                        end
                    end
                    MODE_INT_BODY: begin
                        if (w_byte == bisc_pkg::CH_END) begin
                            w_vd = 1'b1;
                        end
                    end
                    default: begin
                        w_dec = 1'b1;
                    end
                endcase

                // Start of a value in a dictionary or list slot.
                if (w_bv) begin
                    if (w_stk.empty) begin
                        n_info_begin = r_off;
                    end
                    if (w_digit) begin
                        n_rem  = OB'(w_dval);
                        n_mode = MODE_STR_LEN;
                    end else if (w_byte == bisc_pkg::CH_INT) begin
                        n_mode = MODE_INT_BODY;
                    end else if (w_byte == bisc_pkg::CH_LIST ||
                                 w_byte == bisc_pkg::CH_DICT) begin
                        if (w_stk.full) begin
                            w_dec = 1'b1;
                        end else begin
                            w_stk_cmd.push = 1'b1;
                            if (w_byte == bisc_pkg::CH_DICT) begin
                                w_stk_cmd.kind = bisc_pkg::KIND_DICT;
                                n_mode         = MODE_KEY_START;
                            end else begin
                                w_stk_cmd.kind = bisc_pkg::KIND_LIST;
                                n_mode         = MODE_LIST_ITEM;
                            end
                        end
                    end else if (w_byte == bisc_pkg::CH_END && w_bv_dict) begin
                        w_vd = 1'b1;
                    end else begin
                        w_dec = 1'b1;
                    end
                end

                // A key is complete: note whether it was the root key "info".
                if (w_kd) begin
                    if (w_stk.empty) begin
                        n_cur_info = (n_kmp == bisc_pkg::KEY_LEN_INFO);
                    end
                    n_mode = MODE_VALUE;
                end

                // A value is complete: return to the enclosing container.
                if (w_vd) begin
                    w_vd_root = w_vd_pop ? w_stk.single : w_stk.empty;
                    w_vd_kind = w_vd_pop ? w_stk.below_kind : w_stk.top_kind;
                    if (w_vd_root) begin
                        if (r_cur_info) begin
                            w_dec       = 1'b1;
                            w_dec_found = 1'b1;
                            w_dec_start = n_info_begin;
                            w_dec_end   = r_off + OB'(1);
                        end else begin
                            n_mode = MODE_KEY_START;
                        end
                    end else if (w_vd_kind == bisc_pkg::KIND_DICT) begin
                        n_mode = MODE_KEY_START;
                    end else begin
                        n_mode = MODE_LIST_ITEM;
                    end
                end

                // The last byte ends an undecided file as not found.
                if (w_last && !w_dec) begin
                    w_dec = 1'b1;
                end
                if (w_dec) begin
                    n_decided = 1'b1;
                end
            end

            n_off = r_off + OB'(1);

            // Rearm for the next file.
            if (w_last) begin
                n_mode          = MODE_ROOT_OPEN;
                n_off           = '0;
                n_rem           = '0;
                n_kmp           = '0;
                n_cur_info      = 1'b0;
                n_info_begin    = '0;
                n_decided       = 1'b0;
                w_stk_cmd.clear = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_ROOT_OPEN;
            r_off        <= '0;
            r_rem        <= '0;
            r_kmp        <= '0;
            r_cur_info   <= 1'b0;
            r_info_begin <= '0;
            r_decided    <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_off        <= n_off;
            r_rem        <= n_rem;
            r_kmp        <= n_kmp;
            r_cur_info   <= n_cur_info;
            r_info_begin <= n_info_begin;
            r_decided    <= n_decided;
        end
    end

    // Result formatting: offsets zero-extended or truncated to the result width.
    assign w_start_wide     = OW'(w_dec_start);
    assign w_end_wide       = OW'(w_dec_end);
    assign w_res.found      = w_dec_found;
    assign w_res.span_start = w_start_wide[bisc_pkg::RESULT_BITS-1:0];
    assign w_res.span_end   = w_end_wide[bisc_pkg::RESULT_BITS-1:0];

    bisc_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_stk_cmd),
        .o_stat  (w_stk)
    );

    bisc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_dec),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[hw/rtl/bisc_checker.sv]
`default_nettype none

// Port-level checks on the scanner.
module bisc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_out_found,
    input wire [31:0] i_out_span_start,
    input wire [31:0] i_out_span_end
);

    // No result is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A not-found result carries zero offsets.
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_found) |-> (i_out_span_start == 32'd0 &&
                                            i_out_span_end == 32'd0))
        else $error("not-found result with nonzero offsets");

    // With no result waiting, the byte input is always open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result queue");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_found) &&
            $stable(i_out_span_start) && $stable(i_out_span_end)))
        else $error("stalled result changed");

endmodule

bind bencode_info_range_scanner bisc_checker u_bisc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_found      (o_out.found),
    .i_out_span_start (o_out.span_start),
    .i_out_span_end   (o_out.span_end)
);

`default_nettype wire

[sim/bencode_info_range_scanner_test.sv]
module bencode_info_range_scanner_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DEPTH     = bisc_pkg::MAX_DEPTH_DEF;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PHASE_BYTES   = 530;

    // Characters of the key that is searched for.
    localparam logic [7:0] INFO_KEY [4] = '{8'h69, 8'h6E, 8'h66, 8'h6F};

    // Where the scan stands within the file.
    typedef enum logic [3:0] {
        PS_ROOT_OPEN,
        PS_KEY_START,
        PS_KEY_LEN,
        PS_KEY_BODY,
        PS_VALUE,
        PS_LIST_ITEM,
        PS_STR_LEN,
        PS_STR_BODY,
        PS_INT_BODY
    } t_parse_state;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    logic i_clk;
    logic i_rst_n;

    bisc_in_if  in_if ();
    bisc_out_if out_if ();

    bencode_info_range_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Stimulus and expectations.
    t_byte_item         pending_bytes [$];
    bisc_pkg::t_result  expected_ranges [$];
    logic [7:0]         file_buf [$];
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 mismatches;
    int                 queued_bytes;
    int                 stall_cycles;

    // Shadow copy of the scan state.
    t_parse_state      ps;
    logic [31:0]       pos;
    logic [31:0]       remaining;
    logic [31:0]       info_from;
    logic [3:0]        key_prog;
    int                depth;
    logic              kinds [MAX_DEPTH];
    logic              at_info;
    logic              decided;
    logic              emit;
    bisc_pkg::t_result emitted;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic logic digit_char(input logic [7:0] b);
        return (b >= bisc_pkg::CH_ZERO) && (b <= bisc_pkg::CH_NINE);
    endfunction

    // Record the one decision of the current file.
    function automatic void conclude(input logic hit, input logic [31:0] from_pos,
                                     input logic [31:0] to_pos);
        decided = 1'b1;
        emit = 1'b1;
        emitted.found = hit;
        emitted.span_start = hit ? from_pos : '0;
        emitted.span_end = hit ? to_pos : '0;
    endfunction

    // Accumulate one length digit; returns 0 when the length saturates.
    function automatic logic add_length_digit(input logic [7:0] b);
        logic [63:0] d;
        d = {56'd0, b - bisc_pkg::CH_ZERO};
        if ({32'd0, remaining} > (64'hFFFF_FFFF - d) / 64'd10) begin
            return 1'b0;
        end
        remaining = remaining * 32'd10 + d[31:0];
        return 1'b1;
    endfunction

    function automatic void value_closed();
        if (depth == 0) begin
            if (at_info) begin
                conclude(1'b1, info_from, pos + 32'd1);
            end else begin
                ps = PS_KEY_START;
            end
        end else if (kinds[depth-1] == bisc_pkg::KIND_DICT) begin
            ps = PS_KEY_START;
        end else begin
            ps = PS_LIST_ITEM;
        end
    endfunction

    function automatic void key_closed();
        if (depth == 0) begin
            at_info = (key_prog == bisc_pkg::KEY_LEN_INFO);
        end
        ps = PS_VALUE;
    endfunction

    function automatic void open_value(input logic [7:0] b, input logic dict_slot);
        if (depth == 0) begin
            info_from = pos;
        end
        if (digit_char(b)) begin
            remaining = {24'd0, b - bisc_pkg::CH_ZERO};
            ps = PS_STR_LEN;
        end else if (b == bisc_pkg::CH_INT) begin
            ps = PS_INT_BODY;
        end else if (b == bisc_pkg::CH_LIST || b == bisc_pkg::CH_DICT) begin
            if (depth >= MAX_DEPTH) begin
                conclude(1'b0, '0, '0);
            end else begin
                kinds[depth] = (b == bisc_pkg::CH_DICT) ? bisc_pkg::KIND_DICT
                                                         : bisc_pkg::KIND_LIST;
                depth++;
                if (b == bisc_pkg::CH_DICT) begin
                    ps = PS_KEY_START;
                end else begin
                    ps = PS_LIST_ITEM;
                end
            end
        end else if (b == bisc_pkg::CH_END && dict_slot) begin
            // A bare end marker in a dictionary value slot counts as a one-byte value.
            value_closed();
        end else begin
            conclude(1'b0, '0, '0);
        end
    endfunction

    function automatic void scan_char(input logic [7:0] b);
        case (ps)
            PS_ROOT_OPEN: begin
                if (b == bisc_pkg::CH_DICT) begin
                    ps = PS_KEY_START;
                end else begin
                    conclude(1'b0, '0, '0);
                end
            end
            PS_KEY_START: begin
                if (b == bisc_pkg::CH_END) begin
                    if (depth == 0) begin
                        conclude(1'b0, '0, '0);
                    end else begin
                        depth--;
                        value_closed();
                    end
                end else if (digit_char(b)) begin
                    remaining = {24'd0, b - bisc_pkg::CH_ZERO};
                    ps = PS_KEY_LEN;
                end else begin
                    conclude(1'b0, '0, '0);
                end
            end
            PS_KEY_LEN: begin
                if (digit_char(b)) begin
                    if (!add_length_digit(b)) begin
                        conclude(1'b0, '0, '0);
                    end
                end else if (b == bisc_pkg::CH_COLON) begin
                    key_prog = (remaining == 32'd4) ? 4'd0 : bisc_pkg::NO_MATCH;
                    if (remaining == 0) begin
                        key_closed();
                    end else begin
                        ps = PS_KEY_BODY;
                    end
                end else begin
                    conclude(1'b0, '0, '0);
                end
            end
            PS_KEY_BODY: begin
                if (key_prog < bisc_pkg::KEY_LEN_INFO &&
                    b == INFO_KEY[key_prog[1:0]]) begin
                    key_prog = key_prog + 4'd1;
                end else begin
                    key_prog = bisc_pkg::NO_MATCH;
                end
                remaining = remaining - 32'd1;
                if (remaining == 0) begin
                    key_closed();
                end
            end
            PS_VALUE: begin
                open_value(b, 1'b1);
            end
            PS_LIST_ITEM: begin
                if (b == bisc_pkg::CH_END) begin
                    depth--;
                    value_closed();
                end else begin
                    open_value(b, 1'b0);
                end
            end
            PS_STR_LEN: begin
                if (digit_char(b)) begin
                    if (!add_length_digit(b)) begin
                        conclude(1'b0, '0, '0);
                    end
                end else if (b == bisc_pkg::CH_COLON) begin
                    if (remaining == 0) begin
                        value_closed();
                    end else begin
                        ps = PS_STR_BODY;
                    end
                end else begin
                    conclude(1'b0, '0, '0);
                end
            end
            PS_STR_BODY: begin
                remaining = remaining - 32'd1;
                if (remaining == 0) begin
                    value_closed();
                end
            end
            PS_INT_BODY: begin
                if (b == bisc_pkg::CH_END) begin
                    value_closed();
                end
            end
            default: begin
                conclude(1'b0, '0, '0);
            end
        endcase
    endfunction

    function automatic void rearm();
        ps = PS_ROOT_OPEN;
        pos = '0;
        remaining = '0;
        key_prog = '0;
        depth = 0;
        at_info = 1'b0;
        info_from = '0;
        decided = 1'b0;
    endfunction

    // Advance the shadow scan by one accepted byte and queue any decision.
    function automatic void locate_info_step(input logic [7:0] b, input logic last);
        emit = 1'b0;
        if (!decided) begin
            scan_char(b);
        end
        if (!decided && last) begin
            conclude(1'b0, '0, '0);
        end
        if (emit) begin
            expected_ranges.insert(expected_ranges.size(), emitted);
        end
        pos = pos + 32'd1;
        if (last) begin
            rearm();
        end
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        file_buf.insert(file_buf.size(), b);
    endfunction

    function automatic void put_str(input string s);
        foreach (s[i]) begin
            put_byte(s[i]);
        end
    endfunction

    // Length prefix, now and then with a leading zero.
    function automatic void put_len(input int n);
        if ($urandom_range(7) == 0) begin
            put_byte(bisc_pkg::CH_ZERO);
        end
        put_str($sformatf("%0d", n));
    endfunction

    function automatic void put_text(input int n);
        put_len(n);
        put_byte(bisc_pkg::CH_COLON);
        repeat (n) put_byte(8'($urandom_range(255)));
    endfunction

    // Keys lean toward the searched name and names close to it.
    function automatic void gen_key();
        case ($urandom_range(9))
            0, 1, 2, 3: put_str("4:info");
            4: put_str("3:inf");
            5: put_str("5:infoo");
            6: put_str("4:infx");
            7: put_str("0:");
            default: put_text($urandom_range(5));
        endcase
    endfunction

    function automatic void gen_value(input int lvl, input logic dict_slot);
        int pick;
        int n;
        logic [7:0] c;
        pick = $urandom_range((lvl >= 3) ? 9 : 13);
        if (pick <= 4 || (pick == 9 && !dict_slot) || pick == 8) begin
            put_text($urandom_range(6));
        end else if (pick <= 7) begin
            // Integer body: any bytes up to the end marker.
            put_byte(bisc_pkg::CH_INT);
            n = $urandom_range(4);
            repeat (n) begin
                c = 8'($urandom_range(255));
                put_byte((c == bisc_pkg::CH_END) ? bisc_pkg::CH_NINE : c);
            end
            put_byte(bisc_pkg::CH_END);
        end else if (pick == 9) begin
            put_byte(bisc_pkg::CH_END);
        end else if (pick <= 11) begin
            put_byte(bisc_pkg::CH_LIST);
            n = $urandom_range(3);
            repeat (n) gen_value(lvl + 1, 1'b0);
            put_byte(bisc_pkg::CH_END);
        end else begin
            put_byte(bisc_pkg::CH_DICT);
            n = $urandom_range(3);
            repeat (n) begin
                gen_key();
                gen_value(lvl + 1, 1'b1);
            end
            put_byte(bisc_pkg::CH_END);
        end
    endfunction

    function automatic void queue_file();
        t_byte_item it;
        foreach (file_buf[i]) begin
            it.data = file_buf[i];
            it.last = (i == file_buf.size() - 1);
            pending_bytes.insert(pending_bytes.size(), it);
        end
        queued_bytes += file_buf.size();
    endfunction

    function automatic void queue_text(input string s);
        file_buf.delete();
        put_str(s);
        queue_file();
    endfunction

    // One random file: mostly well formed, with noise, deep nesting, huge
    // lengths, and corrupted, truncated or padded variants.
    function automatic void make_random_file();
        int kind;
        int n;
        int keep;
        file_buf.delete();
        kind = $urandom_range(99);
        if (kind < 8) begin
            n = $urandom_range(1, 12);
            put_byte($urandom_range(1) ? bisc_pkg::CH_DICT : 8'($urandom_range(255)));
            repeat (n - 1) put_byte(8'($urandom_range(255)));
        end else if (kind < 11) begin
            // Nesting close to and beyond the stack depth.
            n = $urandom_range(28, 34);
            put_byte(bisc_pkg::CH_DICT);
            put_str("4:info");
            repeat (n) begin
                if ($urandom_range(1)) begin
                    put_byte(bisc_pkg::CH_DICT);
                    put_str("1:k");
                end else begin
                    put_byte(bisc_pkg::CH_LIST);
                end
            end
            put_str("i0e");
            repeat (n + 1) put_byte(bisc_pkg::CH_END);
        end else if (kind < 13) begin
            // Lengths at and past the largest offset.
            put_byte(bisc_pkg::CH_DICT);
            if ($urandom_range(1)) begin
                put_str("1:a");
            end
            case ($urandom_range(2))
                0: put_str("4294967295");
                1: put_str("4294967296");
                default: put_str("99999999999");
            endcase
            put_byte(bisc_pkg::CH_COLON);
            repeat (3) put_byte(8'($urandom_range(255)));
        end else begin
            put_byte(bisc_pkg::CH_DICT);
            n = $urandom_range(4);
            repeat (n) begin
                gen_key();
                gen_value(0, 1'b1);
            end
            put_byte(bisc_pkg::CH_END);
            if ($urandom_range(99) < 15) begin
                file_buf[$urandom_range(file_buf.size() - 1)] = 8'($urandom_range(255));
            end
            if ($urandom_range(99) < 10) begin
                keep = $urandom_range(1, file_buf.size() - 1);
                while (file_buf.size() > keep) void'(file_buf.pop_back());
            end
        end
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(255)));
        end
        queue_file();
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Byte driver: the shadow scan advances on every accepted transaction.
    always @(posedge i_clk) begin : feed
        t_byte_item nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                locate_info_step(in_if.data_byte, in_if.last_byte);
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_bytes.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.data_byte <= nxt.data;
                    in_if.last_byte <= nxt.last;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: each result transaction is matched against the oldest
    // predicted range.
    always @(posedge i_clk) begin : collect
        bisc_pkg::t_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_ranges.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual %0b %0h %0h",
                             $time, out_if.found, out_if.span_start, out_if.span_end);
                end else begin
                    want = expected_ranges.pop_front();
                    check_field("found", {31'd0, want.found}, {31'd0, out_if.found});
                    check_field("span_start", want.span_start, out_if.span_start);
                    check_field("span_end", want.span_end, out_if.span_end);
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : main
        int byte_goal;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        in_if.last_byte = 1'b0;
        out_if.ready = 1'b0;
        mismatches = 0;
        queued_bytes = 0;
        stall_cycles = 0;
        send_idle_pct = 13;
        recv_idle_pct = 85;
        rearm();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed files: bad first byte with the top bit set, truncation,
        // root close, end marker as the info value, bad value start, bad
        // length and bad key start.
        file_buf = '{8'hFF};
        queue_file();
        queue_text("d");
        queue_text("de");
        queue_text("d4:infoee");
        queue_text("d1:ax");
        queue_text("d2x");
        queue_text("dz");

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 85;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            byte_goal = queued_bytes + PHASE_BYTES;
            while (queued_bytes < byte_goal) begin
                if (pending_bytes.size() < 64) begin
                    make_random_file();
                end else begin
                    @(negedge i_clk);
                end
            end
            // Hold the sender until every predicted result has come back.
            while (pending_bytes.size() != 0 || in_if.valid || expected_ranges.size() != 0) begin
                @(negedge i_clk);
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_ranges.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[bencode_info_range_scanner.f]
hw/rtl/bisc_pkg.sv
hw/rtl/bisc_if.sv
hw/rtl/bisc_stack.sv
hw/rtl/bisc_out_buf.sv
hw/rtl/bencode_info_range_scanner.sv
hw/rtl/bisc_checker.sv
sim/bencode_info_range_scanner_test.sv
